// ----- design/motion_strip_note_trigger_macros.svh -----
// Assertion macros shared by the note trigger checkers.
`ifndef MOTION_STRIP_NOTE_TRIGGER_MACROS_SVH
`define MOTION_STRIP_NOTE_TRIGGER_MACROS_SVH

// Checked on every clock edge outside reset.
`define MSNT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MSNT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/msnt_pkg.sv -----
// Types, constants and scale tables for the motion strip note trigger.
package msnt_pkg;

    localparam int LEVEL_W    = 16;
    localparam int VOLUME_W   = 16;
    localparam int STRIP_W    = 4;
    localparam int NOTE_W     = 6;
    localparam int SPEED_W    = 16;
    localparam int SCALE_W    = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_SCALES = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE       = 8'd1;

    // scale codes
    localparam logic [SCALE_W-1:0] SCALE_PENTATONIC = 2'd0;
    localparam logic [SCALE_W-1:0] SCALE_MAJOR      = 2'd1;
    localparam logic [SCALE_W-1:0] SCALE_MINOR      = 2'd2;
    localparam logic [SCALE_W-1:0] SCALE_CHROMATIC  = 2'd3;

    localparam logic [VOLUME_W-1:0] THRESHOLD_RESET = 16'd32768;
    localparam logic [SCALE_W-1:0]  SCALE_RESET     = SCALE_MAJOR;

    localparam int SEMIS      = 12;
    localparam int NOTE_BASE  = 12;
    localparam int MAX_SHIFT  = 4;
    localparam int SPEED_MAX  = 65535;

    typedef struct packed {
        logic [VOLUME_W-1:0] volume_threshold;
        logic [SCALE_W-1:0]  scale_mode;
    } t_cfg;

    // notes per octave for a scale code
    function automatic int msnt_scale_len(input logic [SCALE_W-1:0] mode);
        int n;
        n = 12;
        unique case (mode)
            SCALE_PENTATONIC:         n = 5;
            SCALE_MAJOR, SCALE_MINOR: n = 7;
            default:                  n = 12;
        endcase
        return n;
    endfunction

    // semitone offset of a scale degree
    function automatic int msnt_degree_ofs(input logic [SCALE_W-1:0] mode, input int deg);
        int ofs;
        ofs = deg;
        unique case (mode)
            SCALE_PENTATONIC: begin
                unique case (deg)
                    1:       ofs = 3;
                    2:       ofs = 5;
                    3:       ofs = 7;
                    4:       ofs = 10;
                    default: ofs = 0;
                endcase
            end
            SCALE_MAJOR: begin
                unique case (deg)
                    1:       ofs = 2;
                    2:       ofs = 4;
                    3:       ofs = 5;
                    4:       ofs = 7;
                    5:       ofs = 9;
                    6:       ofs = 11;
                    default: ofs = 0;
                endcase
            end
            SCALE_MINOR: begin
                unique case (deg)
                    1:       ofs = 2;
                    2:       ofs = 3;
                    3:       ofs = 5;
                    4:       ofs = 7;
                    5:       ofs = 8;
                    6:       ofs = 11;
                    default: ofs = 0;
                endcase
            end
            default: ofs = deg;
        endcase
        return ofs;
    endfunction

    // 2^(k/12) in Q3.12
    function automatic int msnt_semitone_q12(input int k);
        int v;
        v = 4096;
        unique case (k)
            1:       v = 4340;
            2:       v = 4598;
            3:       v = 4871;
            4:       v = 5161;
            5:       v = 5468;
            6:       v = 5793;
            7:       v = 6137;
            8:       v = 6502;
            9:       v = 6889;
            10:      v = 7298;
            11:      v = 7732;
            default: v = 4096;
        endcase
        return v;
    endfunction

endpackage

// ----- design/msnt_ifs.sv -----
// Channel interfaces: strip levels in, note events out, register writes.
interface msnt_in_if
    import msnt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

interface msnt_out_if
    import msnt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                note_on;
    logic [STRIP_W-1:0]  strip;
    logic [VOLUME_W-1:0] volume;
    logic [NOTE_W-1:0]   note;
    logic [SPEED_W-1:0]  speed;

    modport source (output valid, output note_on, output strip, output volume,
                    output note, output speed, input ready);
    modport sink   (input valid, input note_on, input strip, input volume,
                    input note, input speed, output ready);
endinterface

interface msnt_cfg_if
    import msnt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/msnt_regs.sv -----
// Configuration registers: volume threshold and scale mode.
module msnt_regs
    import msnt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    msnt_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volume_threshold <= THRESHOLD_RESET;
            r_cfg.scale_mode       <= SCALE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_VOLUME_THRESHOLD: r_cfg.volume_threshold <= i_cfg.data[VOLUME_W-1:0];
                REG_SCALE_MODE:       r_cfg.scale_mode       <= i_cfg.data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/msnt_peak.sv -----
// Running peak search over one frame of strip levels.
module msnt_peak
    import msnt_pkg::*;
#(
    parameter int STRIPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    msnt_in_if.sink                           i_in,
    output logic                              o_frame_valid,
    input  logic                              i_frame_ready,
    output logic [$clog2(STRIPS+1)-1:0]       o_frame_strip,
    output logic [VOLUME_W-1:0]               o_frame_volume
);

    localparam int IDX_W = $clog2(STRIPS + 1);
    localparam int CNT_W = $clog2(STRIPS);
    localparam logic [IDX_W-1:0] NONE = IDX_W'(STRIPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STRIPS - 1);

    logic [CNT_W-1:0]   r_count;
    logic [LEVEL_W-1:0] r_peak_level;
    logic [IDX_W-1:0]   r_peak_idx;
    logic               r_frame_valid;
    logic [IDX_W-1:0]   r_frame_strip;
    logic [VOLUME_W-1:0] r_frame_volume;

    logic               last;
    logic               accept;
    logic               newer;
    logic [LEVEL_W-1:0] n_peak_level;
    logic [IDX_W-1:0]   n_peak_idx;
    logic [VOLUME_W-1:0] n_volume;

    assign last        = (r_count == LAST);
    // only the closing level needs room in the frame register
    assign i_in.ready  = !last || !r_frame_valid || i_frame_ready;
    assign accept      = i_in.valid && i_in.ready;

    // strict compare keeps the first strip on ties
    assign newer        = i_in.level > r_peak_level;
    assign n_peak_level = newer ? i_in.level : r_peak_level;
    assign n_peak_idx   = newer ? IDX_W'(r_count) : r_peak_idx;
    assign n_volume     = n_peak_level[LEVEL_W-1] ? {VOLUME_W{1'b1}}
                                                  : {n_peak_level[LEVEL_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_peak_level  <= '0;
            r_peak_idx    <= NONE;
            r_frame_valid <= 1'b0;
        end else begin
            if (accept && last) begin
                r_frame_valid <= 1'b1;
            end else if (r_frame_valid && i_frame_ready) begin
                r_frame_valid <= 1'b0;
            end
            if (accept) begin
                if (last) begin
                    r_count       <= '0;
                    r_peak_level  <= '0;
                    r_peak_idx    <= NONE;
                end else begin
                    r_count      <= r_count + CNT_W'(1);
                    r_peak_level <= n_peak_level;
                    r_peak_idx   <= n_peak_idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && last) begin
            r_frame_strip  <= n_peak_idx;
            r_frame_volume <= n_volume;
        end
    end

    assign o_frame_valid  = r_frame_valid;
    assign o_frame_strip  = r_frame_strip;
    assign o_frame_volume = r_frame_volume;

endmodule

// ----- design/msnt_trig.sv -----
// Trigger decision, scale lookup and result register.
module msnt_trig
    import msnt_pkg::*;
#(
    parameter int STRIPS  = 16,
    parameter int OCTAVES = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_cfg                              i_cfg,
    input  logic                              i_frame_valid,
    output logic                              o_frame_ready,
    input  logic [$clog2(STRIPS+1)-1:0]       i_frame_strip,
    input  logic [VOLUME_W-1:0]               i_frame_volume,
    msnt_out_if.source                        o_out
);

    localparam int IDX_W = $clog2(STRIPS + 1);
    localparam int CNT_W = $clog2(STRIPS);
    localparam logic [IDX_W-1:0] NONE = IDX_W'(STRIPS);

    // note and speed for every (scale, strip), settled at elaboration
    logic [NOTE_W-1:0]  note_rom  [NUM_SCALES][STRIPS];
    logic [SPEED_W-1:0] speed_rom [NUM_SCALES][STRIPS];

    for (genvar m = 0; m < NUM_SCALES; m++) begin : g_scale
        for (genvar s = 0; s < STRIPS; s++) begin : g_strip
            localparam int N    = msnt_scale_len(SCALE_W'(m));
            localparam int POS  = ((STRIPS - s) * OCTAVES * N) / STRIPS;
            localparam int OCT  = POS / N;
            localparam int DEG  = POS % N;
            localparam int NOTE = OCT * SEMIS + msnt_degree_ofs(SCALE_W'(m), DEG) + NOTE_BASE;
            localparam int SH   = NOTE / SEMIS;
            localparam int RAW  = (SH > MAX_SHIFT) ? SPEED_MAX
                                                   : (msnt_semitone_q12(NOTE % SEMIS) << SH);
            localparam int SPD  = (RAW > SPEED_MAX) ? SPEED_MAX : RAW;
            assign note_rom[m][s]  = NOTE_W'(NOTE);
            assign speed_rom[m][s] = SPEED_W'(SPD);
        end
    end

    logic [IDX_W-1:0]          r_prev;
    logic                      r_valid;
    logic                      r_note_on;
    logic [STRIP_W-1:0]        r_strip;
    logic [VOLUME_W-1:0]       r_volume;
    logic [NOTE_W-1:0]         r_note;
    logic [SPEED_W-1:0]        r_speed;

    logic                      take;
    logic                      differs;
    logic                      fire;
    logic [IDX_W-1:0]          n_prev;
    logic [IDX_W+STRIP_W-1:0]  strip_wide;
    logic [CNT_W-1:0]          row;

    assign o_frame_ready = !r_valid || o_out.ready;
    assign take          = i_frame_valid && o_frame_ready;

    assign differs = i_frame_strip != r_prev;
    assign fire    = differs && (i_frame_strip < NONE)
                     && (i_frame_volume > i_cfg.volume_threshold);
    // a new winner that fails to fire clears the remembered strip
    assign n_prev  = differs ? (fire ? i_frame_strip : NONE) : r_prev;

    assign strip_wide = {{STRIP_W{1'b0}}, i_frame_strip};
    assign row        = i_frame_strip[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= NONE;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_prev  <= n_prev;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_note_on <= fire;
            r_strip   <= fire ? strip_wide[STRIP_W-1:0] : '0;
            r_volume  <= fire ? i_frame_volume : '0;
            r_note    <= fire ? note_rom[i_cfg.scale_mode][row] : '0;
            r_speed   <= fire ? speed_rom[i_cfg.scale_mode][row] : '0;
        end
    end

    assign o_out.valid   = r_valid;
    assign o_out.note_on = r_note_on;
    assign o_out.strip   = r_strip;
    assign o_out.volume  = r_volume;
    assign o_out.note    = r_note;
    assign o_out.speed   = r_speed;

endmodule

// ----- design/motion_strip_note_trigger.sv -----
// Top level of the motion strip note trigger.
//
// One strip motion level (Q0.16) is taken per transaction, one per clock
// outside the closing-level stall below. Every STRIPS levels close a frame and
// produce exactly one result transaction; no result comes between frame ends.
// The first strip holding the strictly greatest level wins (an all-zero frame
// has no winner), the volume is twice that level saturated at 0xFFFF, and a
// note fires when the winner differs from the previously remembered strip and
// the volume is strictly above volume_threshold. A fired note carries the
// strip index, the volume, the note number quantized to the selected scale
// over OCTAVES octaves (offset by 12) and the Q4.12 playback speed; a frame
// that does not fire returns note_on 0 with all other fields 0. The running
// peak compare loads the frame register when the frame's last level is
// accepted; the trigger decision and constant-table lookup then load the
// output register from the frame register once the output register is
// free, and the result is offered from there. The
// output register lets the next frame's levels keep flowing while a result
// waits; only the closing level of a frame stalls, and only when both the
// frame register and the output register are still full. No clearing pass
// is needed after reset. Registers: index 0 volume_threshold (reset 0x8000),
// index 1 scale_mode (reset 1 = major; 0 pentatonic, 2 minor, 3 chromatic);
// writes to other indexes are dropped. Write configuration only while idle.
module motion_strip_note_trigger
    import msnt_pkg::*;
#(
    parameter int STRIPS  = 16,   // strips per frame, 2..16
    parameter int OCTAVES = 2     // octaves spanned by the strips, 1..4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    msnt_in_if.sink      i_in,
    msnt_out_if.source   o_out,
    msnt_cfg_if.sink     i_cfg
);

    localparam int IDX_W = $clog2(STRIPS + 1);

    t_cfg                cfg;
    logic                frame_valid;
    logic                frame_ready;
    logic [IDX_W-1:0]    frame_strip;
    logic [VOLUME_W-1:0] frame_volume;

    // register file, always ready
    msnt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // stage 1: running max over the frame, emits winner and volume
    msnt_peak #(
        .STRIPS (STRIPS)
    ) u_peak (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .o_frame_valid  (frame_valid),
        .i_frame_ready  (frame_ready),
        .o_frame_strip  (frame_strip),
        .o_frame_volume (frame_volume)
    );

    // stage 2: fire decision against previous strip, note/speed lookup
    msnt_trig #(
        .STRIPS  (STRIPS),
        .OCTAVES (OCTAVES)
    ) u_trig (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_frame_valid  (frame_valid),
        .o_frame_ready  (frame_ready),
        .i_frame_strip  (frame_strip),
        .i_frame_volume (frame_volume),
        .o_out          (o_out)
    );

endmodule

// ----- design/msnt_check.sv -----
// Port-level checker for the note trigger, bound to the top level.
`include "motion_strip_note_trigger_macros.svh"

module msnt_check
    import msnt_pkg::*;
#(
    parameter int OCTAVES = 2
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_note_on,
    input logic [STRIP_W-1:0]  i_strip,
    input logic [VOLUME_W-1:0] i_volume,
    input logic [NOTE_W-1:0]   i_note,
    input logic [SPEED_W-1:0]  i_speed
);

    localparam logic [NOTE_W-1:0]  NOTE_LO  = NOTE_W'(NOTE_BASE);
    localparam logic [NOTE_W-1:0]  NOTE_HI  = NOTE_W'(NOTE_BASE + SEMIS * OCTAVES);
    localparam logic [SPEED_W-1:0] SPEED_LO = SPEED_W'(8192);

    `MSNT_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !i_out_valid, "result valid after reset")

    `MSNT_ASSERT(a_out_holds, i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_note_on, i_strip, i_volume, i_note, i_speed}), "stalled result changed")

    `MSNT_ASSERT(a_silent_zero, i_out_valid && !i_note_on |-> i_strip == '0 && i_volume == '0 && i_note == '0 && i_speed == '0, "silent frame carries data")

    `MSNT_ASSERT(a_note_range, i_out_valid && i_note_on |-> i_note >= NOTE_LO && i_note <= NOTE_HI && i_speed >= SPEED_LO && i_volume != '0, "fired note out of range")

endmodule

bind motion_strip_note_trigger msnt_check #(
    .OCTAVES (OCTAVES)
) u_msnt_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_note_on   (o_out.note_on),
    .i_strip     (o_out.strip),
    .i_volume    (o_out.volume),
    .i_note      (o_out.note),
    .i_speed     (o_out.speed)
);

// ----- tb/sv/motion_strip_note_trigger_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the motion strip note trigger: streams frames, predicts, compares.
module motion_strip_note_trigger_tb;
    import msnt_pkg::*;

    localparam int STRIPS        = 16;
    localparam int OCTAVES       = 2;
    localparam int IDX_W         = 7;      // holds 0..STRIPS, STRIPS meaning "no strip"
    localparam int HOLD_CYCLES   = 150;    // long receiver hold-off
    localparam int STALL_LIMIT   = 2000;   // cycles with no transaction anywhere
    localparam int SETTLE_CYCLES = 8;      // well past the result latency
    localparam int LEVEL_MAX     = (1 << LEVEL_W) - 1;

    // Scale step offsets and 2^(k/12) ratios in Q3.12
    localparam int PENT_STEP [5]   = '{0, 3, 5, 7, 10};
    localparam int MAJOR_STEP [7]  = '{0, 2, 4, 5, 7, 9, 11};
    localparam int MINOR_STEP [7]  = '{0, 2, 3, 5, 7, 8, 11};
    localparam int RATIO_Q12 [12]  = '{4096, 4340, 4598, 4871, 5161, 5468,
                                       5793, 6137, 6502, 6889, 7298, 7732};

    typedef struct packed {
        logic                note_on;
        logic [STRIP_W-1:0]  strip;
        logic [VOLUME_W-1:0] volume;
        logic [NOTE_W-1:0]   note;
        logic [SPEED_W-1:0]  speed;
    } t_note_event;

    logic i_clk;
    logic i_rst_n;

    msnt_in_if  in_if ();
    msnt_out_if out_if ();
    msnt_cfg_if cfg_if ();

    motion_strip_note_trigger #(
        .STRIPS  (STRIPS),
        .OCTAVES (OCTAVES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Predictor copy of the configuration and frame state
    logic [VOLUME_W-1:0] cfg_threshold;
    logic [SCALE_W-1:0]  cfg_scale;
    logic [LEVEL_W-1:0]  pk_level;
    logic [IDX_W-1:0]    pk_index;
    logic [IDX_W-1:0]    strip_cnt;
    logic [IDX_W-1:0]    last_strip;

    t_note_event         pending_notes [$];   // one entry per closed frame, oldest first
    logic [LEVEL_W-1:0]  frame_lv [STRIPS];   // frame being built by a test
    int                  errors       = 0;
    int                  idle_cycles  = 0;
    int                  last_winner  = 0;
    bit                  bursts_on    = 1'b1; // random idling on both sides
    bit                  hold_req     = 1'b0; // asks the receiver for a long hold-off

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Note number for a winning strip: its position spread over OCTAVES
    // octaves of the current scale, floor taken exactly, plus the base note.
    function automatic logic [NOTE_W-1:0] scale_note(input logic [IDX_W-1:0] idx);
        int n;
        int pos;
        int ofs;
        case (cfg_scale)
            SCALE_PENTATONIC:         n = 5;
            SCALE_MAJOR, SCALE_MINOR: n = 7;
            default:                  n = SEMIS;
        endcase
        pos = (STRIPS - int'(idx)) * OCTAVES * n / STRIPS;
        case (cfg_scale)
            SCALE_PENTATONIC: ofs = PENT_STEP[pos % n];
            SCALE_MAJOR:      ofs = MAJOR_STEP[pos % n];
            SCALE_MINOR:      ofs = MINOR_STEP[pos % n];
            default:          ofs = pos % n;
        endcase
        return NOTE_W'((pos / n) * SEMIS + ofs + NOTE_BASE);
    endfunction

    // Q4.12 playback rate for a note: semitone ratio shifted by octave, saturated
    function automatic logic [SPEED_W-1:0] note_rate(input logic [NOTE_W-1:0] note);
        int     sh;
        longint v;
        sh = int'(note) / SEMIS;
        if (sh > MAX_SHIFT) return SPEED_W'(SPEED_MAX);
        v = longint'(RATIO_Q12[int'(note) % SEMIS]) << sh;
        if (v > SPEED_MAX) v = SPEED_MAX;
        return SPEED_W'(v);
    endfunction

    // Feed one accepted level; at frame close, queue the expected note event.
    task automatic predict_level(input logic [LEVEL_W-1:0] lvl);
        t_note_event      ev;
        logic [IDX_W-1:0] win;
        int               vol;
        // strictly greater only: first strip of a tie keeps the lead
        if (lvl > pk_level) begin
            pk_level = lvl;
            pk_index = strip_cnt;
        end
        strip_cnt = strip_cnt + 1'b1;
        if (strip_cnt < STRIPS) return;

        win = pk_index;
        vol = 2 * int'(pk_level);
        if (vol > LEVEL_MAX) vol = LEVEL_MAX;
        ev  = '0;
        // same winner as last time: no note, remembered strip kept
        if (win != last_strip) begin
            if (win < STRIPS && vol > int'(cfg_threshold)) begin
                ev.note_on = 1'b1;
                ev.strip   = STRIP_W'(win);
                ev.volume  = VOLUME_W'(vol);
                ev.note    = scale_note(win);
                ev.speed   = note_rate(ev.note);
            end else begin
                win = IDX_W'(STRIPS);   // forget the last strip
            end
        end
        last_strip = win;
        pending_notes.insert(pending_notes.size(), ev);

        pk_level  = '0;
        pk_index  = IDX_W'(STRIPS);
        strip_cnt = '0;
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one level, possibly after an idle burst; returns on the accepting edge.
    task automatic send_level(input logic [LEVEL_W-1:0] lvl);
        int gap;
        gap = (bursts_on && $urandom_range(0, 6) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.level <= lvl;
        do @(posedge i_clk); while (!in_if.ready);
        predict_level(lvl);
    endtask

    task automatic send_frame();
        for (int i = 0; i < STRIPS; i++) send_level(frame_lv[i]);
    endtask

    // Stop offering and wait for every outstanding note event, then let the
    // pipeline settle so the block is idle.
    task automatic drain_events();
        in_if.valid <= 1'b0;
        while (pending_notes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write transaction; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        // values are masked to the register width; other indexes are dropped
        if (idx == REG_VOLUME_THRESHOLD) cfg_threshold = data[VOLUME_W-1:0];
        else if (idx == REG_SCALE_MODE) cfg_scale = data[SCALE_W-1:0];
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);   // keeps the drop of valid apart from the next raise
    endtask

    // Frame with a single winning strip, the rest silent
    task automatic send_single(input int strip, input logic [LEVEL_W-1:0] lvl);
        frame_lv = '{default: '0};
        frame_lv[strip] = lvl;
        send_frame();
    endtask

    // Random frame: mostly one clear winner (often the same as last time, to
    // hit the repeat rule), some ties after the winner, some noise and quiet.
    task automatic send_random_frame();
        int kind;
        int win;
        int peak;
        kind = $urandom_range(0, 19);
        if (kind < 3) begin
            foreach (frame_lv[i]) frame_lv[i] = LEVEL_W'($urandom_range(0, LEVEL_MAX));
        end else if (kind < 5) begin
            foreach (frame_lv[i])
                frame_lv[i] = ($urandom_range(0, 1) == 0) ? '0 : LEVEL_W'($urandom_range(0, 3));
        end else begin
            win = (kind < 9) ? last_winner : $urandom_range(0, STRIPS - 1);
            case ($urandom_range(0, 3))
                0:       peak = $urandom_range(1, LEVEL_MAX);
                1:       peak = $urandom_range(32768, LEVEL_MAX);   // saturating volume
                2:       peak = int'(cfg_threshold) / 2 + $urandom_range(0, 1); // at threshold
                default: peak = $urandom_range(1, 32767);
            endcase
            if (peak < 1) peak = 1;
            if (peak > LEVEL_MAX) peak = LEVEL_MAX;
            foreach (frame_lv[i]) begin
                if (i == win)
                    frame_lv[i] = LEVEL_W'(peak);
                else if (i > win && $urandom_range(0, 7) == 0)
                    frame_lv[i] = LEVEL_W'(peak);             // later tie loses
                else
                    frame_lv[i] = LEVEL_W'($urandom_range(0, peak - 1));
            end
            last_winner = win;
        end
        send_frame();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        forever begin
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Each accepted note event against the oldest expectation, field by field
    always @(posedge i_clk) begin : check_events
        t_note_event want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_notes.size() == 0) begin
                report_mismatch("unexpected note event, note_on", out_if.note_on, 0);
            end else begin
                want = pending_notes.pop_front();
                if (out_if.note_on !== want.note_on)
                    report_mismatch("note_on", out_if.note_on, want.note_on);
                if (out_if.strip !== want.strip)
                    report_mismatch("strip", out_if.strip, want.strip);
                if (out_if.volume !== want.volume)
                    report_mismatch("volume", out_if.volume, want.volume);
                if (out_if.note !== want.note)
                    report_mismatch("note", out_if.note, want.note);
                if (out_if.speed !== want.speed)
                    report_mismatch("speed", out_if.speed, want.speed);
            end
        end
    end

    // Watchdog: too long without any transaction on any channel
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (threshold 0x8000, major): no winner, full-scale winner,
    // repeat winner, tie at exactly the threshold, lowest note.
    task automatic test_directed_frames();
        send_single(0, '0);                        // all zero: no winner
        send_single(0, LEVEL_W'(LEVEL_MAX));       // saturated volume, top note
        send_single(0, LEVEL_W'(LEVEL_MAX));       // same winner: no note, strip kept
        frame_lv = '{default: '0};
        frame_lv[3]  = 16'd16384;                  // tie, first wins, volume == threshold
        frame_lv[15] = 16'd16384;
        send_frame();
        send_single(STRIPS - 1, 16'd16385);        // just above threshold, bottom strip
        send_single(STRIPS - 1, 16'd16385);
        last_winner = STRIPS - 1;
        drain_events();
    endtask

    // Register writes: extremes, masking of wide data, dropped indexes, every scale.
    task automatic test_register_writes();
        logic [SCALE_W-1:0] mode;
        write_reg(REG_VOLUME_THRESHOLD, '0);
        write_reg(REG_SCALE_MODE, {{(CFG_DATA_W-SCALE_W){1'b1}}, SCALE_PENTATONIC});
        write_reg({CFG_IDX_W{1'b1}}, {CFG_DATA_W{1'b1}});          // dropped
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_SCALE_MODE) + 1, (1 << CFG_IDX_W) - 2)),
                  CFG_DATA_W'($urandom_range(0, LEVEL_MAX)));      // dropped
        for (int s = 0; s < NUM_SCALES; s++) begin
            mode = SCALE_W'(s);
            if (s != 0) begin
                drain_events();
                write_reg(REG_SCALE_MODE, CFG_DATA_W'(mode));
            end
            send_single(0, 16'd1);                                 // smallest volume above 0
            send_single($urandom_range(1, STRIPS - 1), LEVEL_W'($urandom_range(1, LEVEL_MAX)));
        end
        drain_events();
    endtask

    // Receiver holds off while levels keep coming, so the block fills and
    // stalls its input; then the sender waits for every result.
    task automatic test_backpressure();
        write_reg(REG_VOLUME_THRESHOLD, THRESHOLD_RESET);
        write_reg(REG_SCALE_MODE, CFG_DATA_W'(SCALE_RESET));
        hold_req = 1'b1;
        repeat (6) send_random_frame();
        drain_events();
        repeat (2) send_random_frame();
        drain_events();
    endtask

    // Random frames under several settings, extremes included
    task automatic test_random_settings();
        logic [VOLUME_W-1:0] thr;
        logic [SCALE_W-1:0]  mode;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0:       begin thr = '0;                     mode = SCALE_PENTATONIC; end
                1:       begin thr = {VOLUME_W{1'b1}};       mode = SCALE_CHROMATIC;  end
                2:       begin thr = VOLUME_W'($urandom);    mode = SCALE_MINOR;      end
                3:       begin thr = THRESHOLD_RESET;        mode = SCALE_MAJOR;      end
                4:       begin thr = VOLUME_W'($urandom);    mode = SCALE_CHROMATIC;  end
                5:       begin thr = VOLUME_W'($urandom);    mode = SCALE_PENTATONIC; end
                default: begin thr = VOLUME_W'($urandom);    mode = SCALE_MAJOR;      end
            endcase
            write_reg(REG_VOLUME_THRESHOLD, CFG_DATA_W'(thr));
            write_reg(REG_SCALE_MODE, CFG_DATA_W'(mode));
            bursts_on = (phase % 3 != 2);          // some phases run without idling
            repeat (3) send_random_frame();
            drain_events();
        end
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_full_rate_stream();
        bursts_on = 1'b0;
        write_reg(REG_VOLUME_THRESHOLD, VOLUME_W'($urandom_range(0, 32768)));
        write_reg(REG_SCALE_MODE, CFG_DATA_W'($urandom_range(0, NUM_SCALES - 1)));
        repeat (3) send_random_frame();
        drain_events();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.level  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data  <= '0;

        cfg_threshold = THRESHOLD_RESET;
        cfg_scale     = SCALE_RESET;
        pk_level      = '0;
        pk_index      = IDX_W'(STRIPS);
        strip_cnt     = '0;
        last_strip    = IDX_W'(STRIPS);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_register_writes();
        test_backpressure();
        test_random_settings();
        test_full_rate_stream();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
